// ----- rtl/core/lsr_pkg.sv -----
// Shared types, widths and register indexes of the Laplacian row generator.
package lsr_pkg;

   localparam int MAX_DIM_DEF = 256;
   localparam int SIZE_W      = 9;
   localparam int COEF_W      = 32;
   localparam int CELL_W      = 8;
   localparam int COL_W       = 24;
   localparam int VAL_W       = 40;
   localparam int N_SLOT      = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Z = 3'd5;

   // Entry slots in ascending column order.
   localparam logic [2:0] SLOT_XM = 3'd0;
   localparam logic [2:0] SLOT_YM = 3'd1;
   localparam logic [2:0] SLOT_ZM = 3'd2;
   localparam logic [2:0] SLOT_CT = 3'd3;
   localparam logic [2:0] SLOT_ZP = 3'd4;
   localparam logic [2:0] SLOT_YP = 3'd5;
   localparam logic [2:0] SLOT_XP = 3'd6;

   typedef struct packed {
      logic        [SIZE_W-1:0] size_x;
      logic        [SIZE_W-1:0] size_y;
      logic        [SIZE_W-1:0] size_z;
      logic signed [COEF_W-1:0] coef_x;
      logic signed [COEF_W-1:0] coef_y;
      logic signed [COEF_W-1:0] coef_z;
   } cfg_type;

   typedef struct packed {
      logic        [COL_W-1:0]  base;
      logic        [COL_W-1:0]  sz_off;
      logic        [COL_W-1:0]  plane_off;
      logic signed [VAL_W-1:0]  diag;
      logic        [N_SLOT-1:0] mask;
      logic                     bad;
   } row_type;

endpackage

// ----- rtl/core/lsr_index.sv -----
// Three-stage pipeline: bound checks, column index products and diagonal sum.
module lsr_index #(
   parameter int MAX_DIM = lsr_pkg::MAX_DIM_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lsr_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lsr_pkg::CELL_W-1:0]  cell_x,
   input  logic [lsr_pkg::CELL_W-1:0]  cell_y,
   input  logic [lsr_pkg::CELL_W-1:0]  cell_z,
   output logic                        row_valid,
   input  logic                        row_ready,
   output lsr_pkg::row_type            row
);

   localparam int SZW   = $clog2(MAX_DIM + 1);
   localparam int CW    = lsr_pkg::CELL_W;
   localparam int XSY_W = CW + SZW;
   localparam int ROW_W = XSY_W + 1;
   localparam int PRD_W = ROW_W + SZW;
   localparam int COL_W = lsr_pkg::COL_W;
   localparam int VAL_W = lsr_pkg::VAL_W;
   localparam int NS    = lsr_pkg::N_SLOT;

   function automatic logic [SZW-1:0] eff_size(input logic [lsr_pkg::SIZE_W-1:0] s);
      if (32'(s) > 32'(MAX_DIM)) begin
         return SZW'(MAX_DIM);
      end else begin
         return SZW'(s);
      end
   endfunction

   // Coefficient times the number of neighbors present on that axis.
   function automatic logic signed [VAL_W-1:0] axis_term(
      input logic signed [lsr_pkg::COEF_W-1:0] c,
      input logic lo,
      input logic hi
   );
      logic signed [VAL_W-1:0] cw;
      cw = VAL_W'(c);
      case ({lo, hi})
         2'b11:   return cw <<< 1;
         2'b10:   return cw;
         2'b01:   return cw;
         default: return '0;
      endcase
   endfunction

   logic [SZW-1:0] sx, sy, sz;
   logic           in_bad;
   logic [NS-1:0]  in_mask;

   logic                    s1_valid_ff, s1_valid_in;
   logic [CW-1:0]           s1_x_ff, s1_y_ff, s1_z_ff;
   logic [SZW-1:0]          s1_sy_ff, s1_sz_ff;
   logic [NS-1:0]           s1_mask_ff;
   logic                    s1_bad_ff;

   logic                    s2_valid_ff, s2_valid_in;
   logic [XSY_W-1:0]        s2_xsy_ff, s2_xsy_in;
   logic [CW-1:0]           s2_y_ff, s2_z_ff;
   logic [SZW-1:0]          s2_sz_ff;
   logic [2*SZW-1:0]        plane_full;
   logic [COL_W-1:0]        s2_plane_ff;
   logic signed [VAL_W-1:0] s2_sxy_ff, s2_sxy_in;
   logic [NS-1:0]           s2_mask_ff;
   logic                    s2_bad_ff;

   logic                    s3_valid_ff, s3_valid_in;
   logic [ROW_W-1:0]        row_sum;
   logic [PRD_W-1:0]        prod;
   logic [COL_W-1:0]        s3_t_ff;
   logic [CW-1:0]           s3_z_ff;
   logic [SZW-1:0]          s3_sz_ff;
   logic [COL_W-1:0]        s3_plane_ff;
   logic signed [VAL_W-1:0] s3_diag_ff, s3_diag_in;
   logic [NS-1:0]           s3_mask_ff;
   logic                    s3_bad_ff;

   logic adv1, adv2, adv3;

   assign adv3      = !s3_valid_ff || row_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   // Stage 1 inputs: effective sizes and neighbor presence.
   always_comb begin
      sx     = eff_size(cfg.size_x);
      sy     = eff_size(cfg.size_y);
      sz     = eff_size(cfg.size_z);
      in_bad = (32'(cell_x) >= 32'(sx)) || (32'(cell_y) >= 32'(sy)) ||
               (32'(cell_z) >= 32'(sz));
      if (in_bad) begin
         in_mask = '0;
         in_mask[lsr_pkg::SLOT_CT] = 1'b1;
      end else begin
         in_mask[lsr_pkg::SLOT_XM] = (cell_x != '0);
         in_mask[lsr_pkg::SLOT_YM] = (cell_y != '0);
         in_mask[lsr_pkg::SLOT_ZM] = (cell_z != '0);
         in_mask[lsr_pkg::SLOT_CT] = 1'b1;
         in_mask[lsr_pkg::SLOT_ZP] = (32'(cell_z) + 32'd1 < 32'(sz));
         in_mask[lsr_pkg::SLOT_YP] = (32'(cell_y) + 32'd1 < 32'(sy));
         in_mask[lsr_pkg::SLOT_XP] = (32'(cell_x) + 32'd1 < 32'(sx));
      end
   end

   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   // Stage 2: x*size_y, the plane stride and the x/y part of the diagonal.
   always_comb begin
      s2_xsy_in  = XSY_W'(s1_x_ff) * XSY_W'(s1_sy_ff);
      plane_full = (2*SZW)'(s1_sy_ff) * (2*SZW)'(s1_sz_ff);
      s2_sxy_in  = axis_term(cfg.coef_x, s1_mask_ff[lsr_pkg::SLOT_XM],
                             s1_mask_ff[lsr_pkg::SLOT_XP]) +
                   axis_term(cfg.coef_y, s1_mask_ff[lsr_pkg::SLOT_YM],
                             s1_mask_ff[lsr_pkg::SLOT_YP]);
   end

   // Stage 3: (x*size_y+y)*size_z and the negated diagonal.
   always_comb begin
      row_sum = ROW_W'(s2_xsy_ff) + ROW_W'(s2_y_ff);
      prod    = PRD_W'(row_sum) * PRD_W'(s2_sz_ff);
      if (s2_bad_ff) begin
         s3_diag_in = '0;
      end else begin
         s3_diag_in = -(s2_sxy_ff + axis_term(cfg.coef_z, s2_mask_ff[lsr_pkg::SLOT_ZM],
                                              s2_mask_ff[lsr_pkg::SLOT_ZP]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_x_ff    <= cell_x;
         s1_y_ff    <= cell_y;
         s1_z_ff    <= cell_z;
         s1_sy_ff   <= sy;
         s1_sz_ff   <= sz;
         s1_mask_ff <= in_mask;
         s1_bad_ff  <= in_bad;
      end
      if (adv2) begin
         s2_xsy_ff   <= s2_xsy_in;
         s2_y_ff     <= s1_y_ff;
         s2_z_ff     <= s1_z_ff;
         s2_sz_ff    <= s1_sz_ff;
         s2_plane_ff <= COL_W'(plane_full);
         s2_sxy_ff   <= s2_sxy_in;
         s2_mask_ff  <= s1_mask_ff;
         s2_bad_ff   <= s1_bad_ff;
      end
      if (adv3) begin
         s3_t_ff     <= COL_W'(prod);
         s3_z_ff     <= s2_z_ff;
         s3_sz_ff    <= s2_sz_ff;
         s3_plane_ff <= s2_plane_ff;
         s3_diag_ff  <= s3_diag_in;
         s3_mask_ff  <= s2_mask_ff;
         s3_bad_ff   <= s2_bad_ff;
      end
   end

   assign row_valid     = s3_valid_ff;
   assign row.base      = s3_bad_ff ? '0 : s3_t_ff + COL_W'(s3_z_ff);
   assign row.sz_off    = COL_W'(s3_sz_ff);
   assign row.plane_off = s3_plane_ff;
   assign row.diag      = s3_diag_ff;
   assign row.mask      = s3_mask_ff;
   assign row.bad       = s3_bad_ff;

endmodule

// ----- rtl/core/lsr_serial.sv -----
// Row buffer that issues one matrix entry per beat into the output register.
module lsr_serial (
   input  logic                                clock,
   input  logic                                reset,
   input  lsr_pkg::cfg_type                    cfg,
   input  logic                                row_valid,
   output logic                                row_ready,
   input  lsr_pkg::row_type                    row,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lsr_pkg::COL_W-1:0]           rsp_col,
   output logic signed [lsr_pkg::VAL_W-1:0]    rsp_val,
   output logic                                rsp_last,
   output logic                                rsp_bad
);

   localparam int NS    = lsr_pkg::N_SLOT;
   localparam int COL_W = lsr_pkg::COL_W;
   localparam int VAL_W = lsr_pkg::VAL_W;

   lsr_pkg::row_type        row_ff;
   logic [NS-1:0]           rem_ff, rem_in;
   logic [2:0]              idx;
   logic [NS-1:0]           rest;
   logic                    is_last, pop, out_free, take;
   logic [COL_W-1:0]        off;
   logic                    neg;
   logic [COL_W-1:0]        col_sel;
   logic signed [VAL_W-1:0] val_sel;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]        rsp_col_ff;
   logic signed [VAL_W-1:0] rsp_val_ff;
   logic                    rsp_last_ff, rsp_bad_ff;

   // Lowest pending slot goes out first.
   always_comb begin
      idx = lsr_pkg::SLOT_CT;
      for (int i = NS - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            idx = 3'(i);
         end
      end
      rest    = rem_ff & ~(NS'(1) << idx);
      is_last = (rest == '0);
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (rem_ff != '0) && out_free;
   assign take      = (rem_ff == '0) || (pop && is_last);
   assign row_ready = take;

   always_comb begin
      if (take && row_valid) begin
         rem_in = row.mask;
      end else if (pop) begin
         rem_in = rest;
      end else begin
         rem_in = rem_ff;
      end
   end

   always_comb begin
      off     = '0;
      neg     = 1'b0;
      val_sel = '0;
      case (idx)
         lsr_pkg::SLOT_XM: begin
            off     = row_ff.plane_off;
            neg     = 1'b1;
            val_sel = VAL_W'(cfg.coef_x);
         end
         lsr_pkg::SLOT_YM: begin
            off     = row_ff.sz_off;
            neg     = 1'b1;
            val_sel = VAL_W'(cfg.coef_y);
         end
         lsr_pkg::SLOT_ZM: begin
            off     = COL_W'(1);
            neg     = 1'b1;
            val_sel = VAL_W'(cfg.coef_z);
         end
         lsr_pkg::SLOT_CT: begin
            val_sel = row_ff.diag;
         end
         lsr_pkg::SLOT_ZP: begin
            off     = COL_W'(1);
            val_sel = VAL_W'(cfg.coef_z);
         end
         lsr_pkg::SLOT_YP: begin
            off     = row_ff.sz_off;
            val_sel = VAL_W'(cfg.coef_y);
         end
         lsr_pkg::SLOT_XP: begin
            off     = row_ff.plane_off;
            val_sel = VAL_W'(cfg.coef_x);
         end
         default: begin
            off     = '0;
            val_sel = '0;
         end
      endcase
      col_sel = neg ? row_ff.base - off : row_ff.base + off;
   end

   assign rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && row_valid) begin
         row_ff <= row;
      end
      if (pop) begin
         rsp_col_ff  <= col_sel;
         rsp_val_ff  <= val_sel;
         rsp_last_ff <= is_last;
         rsp_bad_ff  <= row_ff.bad;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_val   = rsp_val_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_bad   = rsp_bad_ff;

   // A bad coordinate yields one zero beat that closes the row.
   a_bad_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_last_ff && rsp_col_ff == '0 && rsp_val_ff == '0))
      else $error("bad coordinate beat not a lone zero entry");

   // Every loaded row carries its diagonal entry.
   a_row_centre: assert property (@(posedge clock) disable iff (reset)
      (row_valid && take) |=> rem_ff[lsr_pkg::SLOT_CT])
      else $error("loaded row lacks diagonal slot");

   // A pending slot with a free output register always produces a beat.
   a_pop_beat: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("pending entry not issued");

   // A stalled beat keeps the row buffer frozen.
   a_hold_rem: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && rem_ff != '0) |=> $stable(rem_ff))
      else $error("row buffer advanced under stall");

endmodule

// ----- rtl/core/laplacian_stencil_row_generator_unit.sv -----
// Top level of the seven-point Laplacian matrix row generator.
//
//  channel  direction  signals                          payload
//  req      in         req_tvalid/tready/tdata          tdata = cell_x, cell_y, cell_z
//  rsp      out        rsp_tvalid/tready/tdata/tlast/   tdata = column_index, matrix_value;
//                      tuser                            tlast = last_in_row; tuser = bad
//  csr      in         csr_wen/csr_index/csr_wdata      size_x/y/z, coef_x/y/z
//
// A cell passes three pipeline stages (bounds, index products, diagonal) and then
// the row buffer, which issues one entry per cycle while rsp is not stalled. A row
// has n entries (1 to 7); the buffer takes the next row as its last entry goes out.
// The first entry passes the stage registers, row buffer and output register.
// Reset is synchronous; it clears valid bits and sets configuration to its defaults.
// A stall on rsp holds the row buffer and backs up the pipeline stage by stage.
module laplacian_stencil_row_generator_unit #(
   parameter int MAX_DIM = lsr_pkg::MAX_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // cell_x, cell_y, cell_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,  // column_index, matrix_value
   output logic                              rsp_tlast,
   output logic                              rsp_tuser,  // bad_coordinate
   input  logic                              csr_wen,
   input  logic [lsr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = lsr_pkg::CELL_W;

   lsr_pkg::cfg_type cfg_ff;

   logic                               row_valid, row_ready;
   lsr_pkg::row_type                   row;
   logic [lsr_pkg::COL_W-1:0]          col;
   logic signed [lsr_pkg::VAL_W-1:0]   val;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x <= lsr_pkg::SIZE_W'(2);
         cfg_ff.size_y <= lsr_pkg::SIZE_W'(2);
         cfg_ff.size_z <= lsr_pkg::SIZE_W'(2);
         cfg_ff.coef_x <= '0;
         cfg_ff.coef_y <= '0;
         cfg_ff.coef_z <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            lsr_pkg::CSR_SIZE_X: cfg_ff.size_x <= csr_wdata[lsr_pkg::SIZE_W-1:0];
            lsr_pkg::CSR_SIZE_Y: cfg_ff.size_y <= csr_wdata[lsr_pkg::SIZE_W-1:0];
            lsr_pkg::CSR_SIZE_Z: cfg_ff.size_z <= csr_wdata[lsr_pkg::SIZE_W-1:0];
            lsr_pkg::CSR_COEF_X: cfg_ff.coef_x <= csr_wdata[lsr_pkg::COEF_W-1:0];
            lsr_pkg::CSR_COEF_Y: cfg_ff.coef_y <= csr_wdata[lsr_pkg::COEF_W-1:0];
            lsr_pkg::CSR_COEF_Z: cfg_ff.coef_z <= csr_wdata[lsr_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   lsr_index #(
      .MAX_DIM (MAX_DIM)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cell_x    (req_tdata[CW-1:0]),
      .cell_y    (req_tdata[2*CW-1:CW]),
      .cell_z    (req_tdata[3*CW-1:2*CW]),
      .row_valid (row_valid),
      .row_ready (row_ready),
      .row       (row)
   );

   lsr_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .row_valid (row_valid),
      .row_ready (row_ready),
      .row       (row),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_col   (col),
      .rsp_val   (val),
      .rsp_last  (rsp_tlast),
      .rsp_bad   (rsp_tuser)
   );

   assign rsp_tdata = {val, col};

endmodule
